[hdl/assert_macros.svh]
// concurrent assertion macros for the configuration port design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define SIOAB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// next-cycle implication, checked outside reset
`define SIOAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define SIOAB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SIOAB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/sioab_pkg.sv]
// shared types and constants of the index/data configuration port
`default_nettype none

package sioab_pkg;

  // logical device number of the bus bridge
  localparam logic [3:0] BRIDGE_DEVICE_ID = 4'd13;

  // transfer kinds on the input channel
  localparam logic [1:0] ACT_READ     = 2'd0;
  localparam logic [1:0] ACT_WRITE    = 2'd1;
  localparam logic [1:0] ACT_COMPLETE = 2'd2;

  // port numbers
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  // result kinds
  localparam logic KIND_READ_DATA = 1'b0;
  localparam logic KIND_BUS_REQ   = 1'b1;

  // index port commands
  localparam logic [7:0] CMD_UNLOCK = 8'hA5;
  localparam logic [7:0] CMD_LOCK   = 8'hAA;
  localparam logic [7:0] CMD_TRIGGER_WRITE = 8'hCF;

  // register indexes
  localparam logic [7:0] IDX_SELECT     = 8'h07;
  localparam logic [7:0] IDX_SCRATCH_LO = 8'h20;
  localparam logic [7:0] IDX_SCRATCH_HI = 8'h2F;
  localparam logic [7:0] IDX_ENABLE     = 8'h30;
  localparam logic [7:0] IDX_SERIRQ_LO  = 8'h70;
  localparam logic [7:0] IDX_SERIRQ_HI  = 8'h73;
  localparam logic [7:0] IDX_ADDR_LO    = 8'hF0;
  localparam logic [7:0] IDX_ADDR_HI    = 8'hF3;
  localparam logic [7:0] IDX_DATA_LO    = 8'hF4;
  localparam logic [7:0] IDX_DATA_HI    = 8'hF7;
  localparam logic [7:0] IDX_SIZE       = 8'hF8;
  localparam logic [7:0] IDX_TRIGGER    = 8'hFE;

  // lock counter values
  localparam logic [1:0] LOCK_FULL = 2'd2;
  localparam logic [1:0] LOCK_OPEN = 2'd0;

  // outstanding bus request codes
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_READ  = 2'd1;
  localparam logic [1:0] PEND_WRITE = 2'd2;

  localparam int SCRATCH_DEPTH = 16;
  localparam int SCRATCH_AW    = $clog2(SCRATCH_DEPTH);

  // one result item, plus a flag to take read data from the scratch memory
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  read_byte;
    logic [31:0] bus_address;
    logic [31:0] bus_write_data;
    logic        bus_is_write;
    logic [1:0]  bus_size_code;
    logic        use_mem;
  } res_t;

  // scratch memory access request
  typedef struct packed {
    logic                  we;
    logic [SCRATCH_AW-1:0] waddr;
    logic [7:0]            wdata;
    logic                  re;
    logic [SCRATCH_AW-1:0] raddr;
  } mem_req_t;

  // control status seen by the top level
  typedef struct packed {
    logic [1:0] lock_count;
    logic [1:0] pending;
  } status_t;

endpackage

`default_nettype wire

[hdl/sioab_scratch_mem.sv]
// scratch register file held in a synchronous memory with registered read
`default_nettype none

module sioab_scratch_mem
  import sioab_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mem_req_t req,
  output logic [7:0]    rdata
);

  logic [7:0]               mem [SCRATCH_DEPTH];
  logic [SCRATCH_DEPTH-1:0] written_r;
  logic [7:0]               rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // entries read as zero until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (req.we) begin
      written_r[req.waddr] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= written_r[req.raddr] ? mem[req.raddr] : 8'd0;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/sioab_regs.sv]
// register decode, control state and bridge registers
`default_nettype none

module sioab_regs
  import sioab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [1:0]  action,
  input  wire logic        port_select,
  input  wire logic [7:0]  write_byte,
  input  wire logic [31:0] bus_read_data,
  input  wire logic        bus_error,
  output res_t             res,
  output logic             res_valid,
  output mem_req_t         mem_req,
  output status_t          status
);

  logic [7:0]  index_r, index_nxt;
  logic [1:0]  lock_r, lock_nxt;
  logic [3:0]  select_r, select_nxt;
  logic [7:0]  enable_r, enable_nxt;
  logic [31:0] baddr_r, baddr_nxt;
  logic [31:0] bdata_r, bdata_nxt;
  logic [7:0]  bsize_r, bsize_nxt;
  logic [1:0]  pend_r, pend_nxt;

  logic [7:0]  r;
  logic [7:0]  en_tmp;
  logic        active_rd;
  logic        active_wr;
  logic [7:0]  addr_lane;
  logic [7:0]  data_lane;
  logic [1:0]  lock_dec;

  assign r = index_r;

  // big-endian byte lanes of the bridge words
  always_comb begin
    case (r[1:0])
      2'd0:    addr_lane = baddr_r[31:24];
      2'd1:    addr_lane = baddr_r[23:16];
      2'd2:    addr_lane = baddr_r[15:8];
      default: addr_lane = baddr_r[7:0];
    endcase
    case (r[1:0])
      2'd0:    data_lane = bdata_r[31:24];
      2'd1:    data_lane = bdata_r[23:16];
      2'd2:    data_lane = bdata_r[15:8];
      default: data_lane = bdata_r[7:0];
    endcase
  end

  // bridge active check, for writes with the enable bit as it is after the write
  assign en_tmp    = (r == IDX_ENABLE) ? {7'd0, write_byte[0]} : enable_r;
  assign active_rd = (lock_r == LOCK_OPEN) && (select_r == BRIDGE_DEVICE_ID) && enable_r[0];
  assign active_wr = (lock_r == LOCK_OPEN) && (select_r == BRIDGE_DEVICE_ID) && en_tmp[0];
  assign lock_dec  = (lock_r != LOCK_OPEN) ? lock_r - 2'd1 : LOCK_OPEN;

  // decode of one transfer
  always_comb begin
    index_nxt  = index_r;
    lock_nxt   = lock_r;
    select_nxt = select_r;
    enable_nxt = enable_r;
    baddr_nxt  = baddr_r;
    bdata_nxt  = bdata_r;
    bsize_nxt  = bsize_r;
    pend_nxt   = pend_r;

    res       = '0;
    res.read_byte = 8'hFF;
    res_valid = 1'b0;

    mem_req       = '0;
    mem_req.waddr = r[SCRATCH_AW-1:0];
    mem_req.raddr = r[SCRATCH_AW-1:0];
    mem_req.wdata = write_byte;

    case (action)
      ACT_READ: begin
        res_valid = 1'b1;
        if (port_select == PORT_DATA) begin
          if (r < IDX_ENABLE) begin
            if (r == IDX_SELECT) begin
              res.read_byte = {4'd0, select_r};
            end else if (r inside {[IDX_SCRATCH_LO:IDX_SCRATCH_HI]}) begin
              res.read_byte = 8'h00;
              res.use_mem   = 1'b1;
              mem_req.re    = 1'b1;
            end else begin
              res.read_byte = 8'h00;
            end
          end else if (active_rd) begin
            if (r == IDX_ENABLE) begin
              res.read_byte = enable_r;
            end else if (r inside {[IDX_ADDR_LO:IDX_ADDR_HI]}) begin
              res.read_byte = addr_lane;
            end else if (r inside {[IDX_DATA_LO:IDX_DATA_HI]}) begin
              res.read_byte = data_lane;
            end else if (r == IDX_SIZE) begin
              res.read_byte = bsize_r;
            end else if (r == IDX_TRIGGER) begin
              // bus read request
              res.result_kind   = KIND_BUS_REQ;
              res.read_byte     = 8'h00;
              res.bus_address   = baddr_r;
              res.bus_size_code = bsize_r[1:0];
              pend_nxt          = PEND_READ;
            end
          end
        end
      end
      ACT_WRITE: begin
        if (port_select == PORT_INDEX) begin
          if (write_byte == CMD_UNLOCK) begin
            lock_nxt = lock_dec;
            if (lock_dec == LOCK_OPEN) begin
              select_nxt = 4'd0;
              enable_nxt = 8'd0;
            end
          end else if (write_byte == CMD_LOCK) begin
            lock_nxt = LOCK_FULL;
          end else begin
            index_nxt = write_byte;
          end
        end else if (lock_r == LOCK_OPEN) begin
          if (r == IDX_SELECT) begin
            if (write_byte[7:4] == 4'd0) begin
              select_nxt = write_byte[3:0];
              enable_nxt = 8'd0;
            end
          end else if (r inside {[IDX_SCRATCH_LO:IDX_SCRATCH_HI]}) begin
            mem_req.we = 1'b1;
          end else if (r inside {[IDX_SERIRQ_LO:IDX_SERIRQ_HI]}) begin
            // serial irq registers are write-only and drive nothing here
            enable_nxt = enable_r;
          end else begin
            if (r == IDX_ENABLE) begin
              enable_nxt = en_tmp;
            end
            if (active_wr) begin
              if (r == IDX_ENABLE) begin
                enable_nxt = write_byte;
              end else if (r inside {[IDX_ADDR_LO:IDX_ADDR_HI]}) begin
                case (r[1:0])
                  2'd0:    baddr_nxt[31:24] = write_byte;
                  2'd1:    baddr_nxt[23:16] = write_byte;
                  2'd2:    baddr_nxt[15:8]  = write_byte;
                  default: baddr_nxt[7:0]   = write_byte;
                endcase
              end else if (r inside {[IDX_DATA_LO:IDX_DATA_HI]}) begin
                case (r[1:0])
                  2'd0:    bdata_nxt[31:24] = write_byte;
                  2'd1:    bdata_nxt[23:16] = write_byte;
                  2'd2:    bdata_nxt[15:8]  = write_byte;
                  default: bdata_nxt[7:0]   = write_byte;
                endcase
              end else if (r == IDX_SIZE) begin
                bsize_nxt = write_byte;
              end else if (r == IDX_TRIGGER && write_byte == CMD_TRIGGER_WRITE) begin
                // bus write request
                res_valid          = 1'b1;
                res.result_kind    = KIND_BUS_REQ;
                res.read_byte      = 8'h00;
                res.bus_address    = baddr_r;
                res.bus_write_data = bdata_r;
                res.bus_is_write   = 1'b1;
                res.bus_size_code  = bsize_r[1:0];
                pend_nxt           = PEND_WRITE;
              end
            end
          end
        end
      end
      ACT_COMPLETE: begin
        // only a pending read gets an answer
        if (pend_r == PEND_READ) begin
          res_valid     = 1'b1;
          res.read_byte = bus_error ? 8'hFF : 8'h00;
          if (!bus_error) begin
            bdata_nxt = bus_read_data;
          end
        end
        pend_nxt = PEND_NONE;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase

    // gate side effects on the transfer
    mem_req.we = mem_req.we & accept;
    mem_req.re = mem_req.re & accept;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r  <= 8'd0;
      lock_r   <= LOCK_FULL;
      select_r <= 4'd0;
      enable_r <= 8'd0;
      baddr_r  <= 32'd0;
      bdata_r  <= 32'd0;
      bsize_r  <= 8'd0;
      pend_r   <= PEND_NONE;
    end else if (accept) begin
      index_r  <= index_nxt;
      lock_r   <= lock_nxt;
      select_r <= select_nxt;
      enable_r <= enable_nxt;
      baddr_r  <= baddr_nxt;
      bdata_r  <= bdata_nxt;
      bsize_r  <= bsize_nxt;
      pend_r   <= pend_nxt;
    end
  end

  assign status.lock_count = lock_r;
  assign status.pending    = pend_r;

endmodule

`default_nettype wire

[hdl/sioab_out_stage.sv]
// memory wait stage and output register of the result channel
`default_nettype none

module sioab_out_stage
  import sioab_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire res_t       res,
  input  wire logic [7:0] mem_rdata,
  output logic            in_ready,
  output logic            s1_valid,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_result_kind,
  output logic [7:0]      out_read_byte,
  output logic [31:0]     out_bus_address,
  output logic [31:0]     out_bus_write_data,
  output logic            out_bus_is_write,
  output logic [1:0]      out_bus_size_code
);

  logic s1_valid_r;
  res_t s1_res_r;
  res_t s1_fwd;
  logic out_valid_r;
  res_t out_res_r;
  logic s1_move;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;

  // stage waiting on scratch read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_res_r <= res;
    end
  end

  // merge scratch read data into the waiting result
  always_comb begin
    s1_fwd = s1_res_r;
    if (s1_res_r.use_mem) begin
      s1_fwd.read_byte = mem_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= s1_fwd;
    end
  end

  assign s1_valid           = s1_valid_r;
  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_res_r.result_kind;
  assign out_read_byte      = out_res_r.read_byte;
  assign out_bus_address    = out_res_r.bus_address;
  assign out_bus_write_data = out_res_r.bus_write_data;
  assign out_bus_is_write   = out_res_r.bus_is_write;
  assign out_bus_size_code  = out_res_r.bus_size_code;

endmodule

`default_nettype wire

[hdl/superio_config_port_ahb_bridge_unit.sv]
// top level of the index/data configuration port with bus bridge
// a result passes the memory wait stage and then the output register before it is offered
// throughput: one transfer per cycle; input stalls only while both result stages are full
// transfers that cause no result update state only and leave the result path idle
// reset: synchronous active-low rst_n, port locked, registers and scratch zero, no request
`default_nettype none

`include "assert_macros.svh"

module superio_config_port_ahb_bridge_unit
  import sioab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic        in_port_select,
  input  wire logic [7:0]  in_write_byte,
  input  wire logic [31:0] in_bus_read_data,
  input  wire logic        in_bus_error,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [7:0]       out_read_byte,
  output logic [31:0]      out_bus_address,
  output logic [31:0]      out_bus_write_data,
  output logic             out_bus_is_write,
  output logic [1:0]       out_bus_size_code
);

  logic     accept;
  res_t     res;
  logic     res_valid;
  mem_req_t mem_req;
  logic [7:0] mem_rdata;
  status_t  status;
  logic     s1_valid;
  logic     out_req_shown;
  logic     out_read_shown;
  logic     read_bus_clear;
  logic     req_load;

  assign accept = in_valid && in_ready;

  // decode and register state
  sioab_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .action        (in_action),
    .port_select   (in_port_select),
    .write_byte    (in_write_byte),
    .bus_read_data (in_bus_read_data),
    .bus_error     (in_bus_error),
    .res           (res),
    .res_valid     (res_valid),
    .mem_req       (mem_req),
    .status        (status)
  );

  // scratch storage
  sioab_scratch_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // result path
  sioab_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (accept && res_valid),
    .res                (res),
    .mem_rdata          (mem_rdata),
    .in_ready           (in_ready),
    .s1_valid           (s1_valid),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_read_byte      (out_read_byte),
    .out_bus_address    (out_bus_address),
    .out_bus_write_data (out_bus_write_data),
    .out_bus_is_write   (out_bus_is_write),
    .out_bus_size_code  (out_bus_size_code)
  );

  // terms for the checks
  assign out_req_shown  = out_valid && out_result_kind;
  assign out_read_shown = out_valid && !out_result_kind;
  assign read_bus_clear = (out_bus_address == 32'd0) && !out_bus_is_write;
  assign req_load       = accept && res_valid && res.result_kind;

  // checks
  `SIOAB_ASSERT_IMPLY(a_lock_range, clk, rst_n, 1'b1, status.lock_count != 2'd3)
  `SIOAB_ASSERT_IMPLY(a_stall_full, clk, rst_n, !in_ready, s1_valid && out_valid)
  `SIOAB_ASSERT_IMPLY(a_req_no_byte, clk, rst_n, out_req_shown, out_read_byte == 8'h00)
  `SIOAB_ASSERT_IMPLY(a_read_no_bus, clk, rst_n, out_read_shown, read_bus_clear)
  `SIOAB_ASSERT_NEXT(a_req_pending, clk, rst_n, req_load, status.pending != PEND_NONE)

endmodule

`default_nettype wire

[tb/superio_config_port_ahb_bridge_unit_test.sv]
// self-checking testbench for the index/data configuration port with bus bridge
`timescale 1ns / 1ps

module superio_config_port_ahb_bridge_unit_test
  import sioab_pkg::*;
();

  localparam int          RESET_CYCLES = 8;
  localparam int          IDLE_PCT     = 31;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          HOLD_CYCLES  = 150;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          TAIL_CYCLES  = 10;
  localparam logic [1:0]  ACT_IGNORED  = 2'd3;
  localparam logic [7:0]  SELECT_MAX   = 8'h0F;

  // one port reply: read byte or bus request
  typedef struct packed {
    logic        kind;
    logic [7:0]  rbyte;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic        is_wr;
    logic [1:0]  size;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_READ;
  logic        in_port_select = PORT_INDEX;
  logic [7:0]  in_write_byte = 8'h00;
  logic [31:0] in_bus_read_data = 32'h0;
  logic        in_bus_error = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_read_byte;
  logic [31:0] out_bus_address;
  logic [31:0] out_bus_write_data;
  logic        out_bus_is_write;
  logic [1:0]  out_bus_size_code;

  // predicted register state of the port
  logic [7:0]  cp_index   = 8'h00;
  logic [1:0]  cp_lock    = LOCK_FULL;
  logic [3:0]  cp_select  = 4'h0;
  logic [7:0]  cp_enable  = 8'h00;
  logic [7:0]  cp_scratch [16] = '{default: 8'h00};
  logic [7:0]  cp_serirq  [4]  = '{default: 8'h00};
  logic [31:0] cp_addr    = 32'h0;
  logic [31:0] cp_data    = 32'h0;
  logic [7:0]  cp_size    = 8'h00;
  logic [1:0]  cp_pending = PEND_NONE;

  reply_t reply_q [$];
  int     mismatches    = 0;
  int     items_sent    = 0;
  int     hold_requests = 0;
  int     idle_cycles   = 0;
  bit     steady        = 1'b0;

  superio_config_port_ahb_bridge_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_port_select    (in_port_select),
    .in_write_byte     (in_write_byte),
    .in_bus_read_data  (in_bus_read_data),
    .in_bus_error      (in_bus_error),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_read_byte     (out_read_byte),
    .out_bus_address   (out_bus_address),
    .out_bus_write_data(out_bus_write_data),
    .out_bus_is_write  (out_bus_is_write),
    .out_bus_size_code (out_bus_size_code)
  );

  always #6 clk = ~clk;

  // bridge device reachable: unlocked, selected and enabled
  function automatic bit bridge_on();
    return cp_lock == LOCK_OPEN && cp_select == BRIDGE_DEVICE_ID && cp_enable[0];
  endfunction

  // build a bus request from the bridge registers and mark it outstanding
  function automatic reply_t bus_request(input bit is_wr);
    reply_t req;
    req       = '0;
    req.kind  = KIND_BUS_REQ;
    req.addr  = cp_addr;
    req.wdata = is_wr ? cp_data : 32'h0;
    req.is_wr = is_wr;
    req.size  = cp_size[1:0];
    cp_pending = is_wr ? PEND_WRITE : PEND_READ;
    return req;
  endfunction

  // update the predicted state for one transfer; returns 1 when a reply follows
  function automatic bit apply_port_access(input logic [1:0] act, input logic port,
                                           input logic [7:0] wb, input logic [31:0] rd,
                                           input logic err, output reply_t rep);
    logic [7:0] r;
    logic [7:0] v;
    bit         has;
    bit         is_req;
    int         sh;
    r      = cp_index;
    v      = 8'hFF;
    has    = 1'b0;
    is_req = 1'b0;
    sh     = 24 - 8 * int'(r[1:0]);
    rep    = '0;
    case (act)
      ACT_READ: begin
        has = 1'b1;
        if (port == PORT_INDEX) begin
          v = 8'hFF;
        end else if (r < IDX_ENABLE) begin
          // low registers answer even while locked
          if (r == IDX_SELECT) v = {4'h0, cp_select};
          else if (r >= IDX_SCRATCH_LO && r <= IDX_SCRATCH_HI) v = cp_scratch[r[3:0]];
          else v = 8'h00;
        end else if (bridge_on()) begin
          if (r == IDX_ENABLE) v = cp_enable;
          else if (r >= IDX_ADDR_LO && r <= IDX_ADDR_HI) v = cp_addr[sh +: 8];
          else if (r >= IDX_DATA_LO && r <= IDX_DATA_HI) v = cp_data[sh +: 8];
          else if (r == IDX_SIZE) v = cp_size;
          else if (r == IDX_TRIGGER) is_req = 1'b1;
        end
        if (is_req) begin
          rep = bus_request(1'b0);
        end else begin
          rep.kind  = KIND_READ_DATA;
          rep.rbyte = v;
        end
      end
      ACT_WRITE: begin
        if (port == PORT_INDEX) begin
          if (wb == CMD_UNLOCK) begin
            if (cp_lock != LOCK_OPEN) cp_lock = cp_lock - 2'd1;
            if (cp_lock == LOCK_OPEN) begin
              cp_select = 4'h0;
              cp_enable = 8'h00;
            end
          end else if (wb == CMD_LOCK) begin
            cp_lock = LOCK_FULL;
          end else begin
            cp_index = wb;
          end
        end else if (cp_lock == LOCK_OPEN) begin
          if (r == IDX_SELECT) begin
            if (wb <= SELECT_MAX) begin
              cp_select = wb[3:0];
              cp_enable = 8'h00;
            end
          end else if (r >= IDX_SCRATCH_LO && r <= IDX_SCRATCH_HI) begin
            cp_scratch[r[3:0]] = wb;
          end else if (r >= IDX_SERIRQ_LO && r <= IDX_SERIRQ_HI) begin
            cp_serirq[r[1:0]] = wb;
          end else begin
            // enable keeps bit 0 first, the full byte once the bridge is live
            if (r == IDX_ENABLE) cp_enable = {7'b0, wb[0]};
            if (bridge_on()) begin
              if (r == IDX_ENABLE) cp_enable = wb;
              else if (r >= IDX_ADDR_LO && r <= IDX_ADDR_HI) cp_addr[sh +: 8] = wb;
              else if (r >= IDX_DATA_LO && r <= IDX_DATA_HI) cp_data[sh +: 8] = wb;
              else if (r == IDX_SIZE) cp_size = wb;
              else if (r == IDX_TRIGGER && wb == CMD_TRIGGER_WRITE) begin
                rep = bus_request(1'b1);
                has = 1'b1;
              end
            end
          end
        end
      end
      ACT_COMPLETE: begin
        // only an outstanding read is answered
        if (cp_pending == PEND_READ) begin
          if (!err) cp_data = rd;
          rep.kind  = KIND_READ_DATA;
          rep.rbyte = err ? 8'hFF : 8'h00;
          has       = 1'b1;
        end
        cp_pending = PEND_NONE;
      end
      default: ;
    endcase
    return has;
  endfunction

  // offer one transfer, hold it until accepted, then predict its reply
  task automatic send_item(input logic [1:0] act, input logic port, input logic [7:0] wb,
                           input logic [31:0] rd, input logic err);
    reply_t rep;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_port_select   <= port;
    in_write_byte    <= wb;
    in_bus_read_data <= rd;
    in_bus_error     <= err;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (apply_port_access(act, port, wb, rd, err, rep)) reply_q.push_back(rep);
    items_sent++;
  endtask

  task automatic index_write(input logic [7:0] v);
    send_item(ACT_WRITE, PORT_INDEX, v, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic data_write(input logic [7:0] v);
    send_item(ACT_WRITE, PORT_DATA, v, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic data_read();
    send_item(ACT_READ, PORT_DATA, 8'($urandom_range(255)), $urandom,
              1'($urandom_range(1)));
  endtask

  task automatic index_read();
    send_item(ACT_READ, PORT_INDEX, 8'($urandom_range(255)), $urandom,
              1'($urandom_range(1)));
  endtask

  task automatic bus_complete(input logic [31:0] rd, input logic err);
    send_item(ACT_COMPLETE, 1'($urandom_range(1)), 8'($urandom_range(255)), rd, err);
  endtask

  // sender stops and waits for every predicted reply
  task automatic wait_replies_done();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // accesses right after reset while the port is locked
  task automatic test_locked_access();
    index_read();
    index_write(IDX_TRIGGER);
    data_read();
    bus_complete(32'hFFFF_FFFF, 1'b0);
    send_item(ACT_IGNORED, PORT_DATA, 8'hFF, 32'hFFFF_FFFF, 1'b1);
  endtask

  // unlock sequence and device select, including an out of range select
  task automatic test_unlock_select();
    index_write(CMD_UNLOCK);
    index_write(CMD_UNLOCK);
    index_write(IDX_SELECT);
    data_write(SELECT_MAX + 8'd1);
    data_write({4'h0, BRIDGE_DEVICE_ID});
    data_read();
  endtask

  // enable write stores the whole byte once the bridge is live
  task automatic test_enable_write();
    index_write(IDX_ENABLE);
    data_write(8'hFF);
    data_read();
  endtask

  // bus triggers, replacement of an outstanding request and completions
  task automatic test_bus_requests();
    index_write(IDX_SIZE);
    data_write(8'hFF);
    index_write(IDX_TRIGGER);
    data_write(8'h00);
    data_write(CMD_TRIGGER_WRITE);
    data_read();
    bus_complete(32'h0000_0000, 1'b1);
    data_read();
    index_read();
    bus_complete(32'hFFFF_FFFF, 1'b0);
    bus_complete(32'h0000_0000, 1'b0);
  endtask

  // write-only serirq, then low register read with the port locked
  task automatic test_low_registers();
    index_write(IDX_SERIRQ_HI);
    data_write(8'hA5);
    data_read();
    index_write(CMD_LOCK);
    index_write(IDX_SCRATCH_HI);
    data_read();
  endtask

  // receiver holds off while the sender keeps offering reads
  task automatic test_output_backpressure();
    hold_requests++;
    repeat (24) index_read();
    wait_replies_done();
  endtask

  function automatic logic [7:0] pick_register();
    case ($urandom_range(9))
      0:       return IDX_SELECT;
      1:       return IDX_SCRATCH_LO + 8'($urandom_range(15));
      2:       return IDX_ENABLE;
      3:       return IDX_SERIRQ_LO + 8'($urandom_range(3));
      4:       return IDX_ADDR_LO + 8'($urandom_range(3));
      5:       return IDX_DATA_LO + 8'($urandom_range(3));
      6:       return IDX_SIZE;
      7, 8:    return IDX_TRIGGER;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one random register access inside an open session
  task automatic random_access();
    logic [7:0] idx;
    logic [7:0] wb;
    int         pick;
    idx  = pick_register();
    pick = $urandom_range(99);
    wb   = (idx == IDX_TRIGGER && $urandom_range(3) != 0) ? CMD_TRIGGER_WRITE
                                                        : 8'($urandom_range(255));
    if (pick < 30) begin
      index_write(idx);
      data_write(wb);
    end else if (pick < 60) begin
      index_write(idx);
      data_read();
    end else if (pick < 72) begin
      data_write(wb);
    end else if (pick < 82) begin
      data_read();
    end else if (pick < 94) begin
      bus_complete($urandom, $urandom_range(3) == 0);
    end else if (pick < 97) begin
      index_read();
    end else begin
      send_item(ACT_IGNORED, 1'($urandom_range(1)), 8'($urandom_range(255)), $urandom,
                1'($urandom_range(1)));
    end
  endtask

  // mostly unlock/select/enable sessions with random accesses, some raw noise
  task automatic test_random_traffic();
    int start;
    int done;
    start = items_sent;
    done  = 0;
    while (done < RANDOM_ITEMS) begin
      steady = (done >= 150 && done < 240);
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(3) == 0) index_write(CMD_LOCK);
        index_write(CMD_UNLOCK);
        index_write(CMD_UNLOCK);
        index_write(IDX_SELECT);
        data_write(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                            : {4'h0, BRIDGE_DEVICE_ID});
        index_write(IDX_ENABLE);
        data_write(8'($urandom_range(255)) | 8'($urandom_range(7) != 0));
        repeat ($urandom_range(4, 14)) random_access();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                    8'($urandom_range(255)), $urandom, 1'($urandom_range(1)));
      end
      done = items_sent - start;
    end
    steady = 1'b0;
  endtask

  // result side ready, with random stalls and a counted hold-off
  always @(posedge clk) begin : drive_out_ready
    int hold_seen;
    int hold_left;
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // compare each result transfer with the oldest predicted reply
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result transfer, kind %0d byte 0x%0h", out_result_kind,
               out_read_byte);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(out_result_kind));
        check_field("read_byte", 32'(want.rbyte), 32'(out_read_byte));
        check_field("bus_address", want.addr, out_bus_address);
        check_field("bus_write_data", want.wdata, out_bus_write_data);
        check_field("bus_is_write", 32'(want.is_wr), 32'(out_bus_is_write));
        check_field("bus_size_code", 32'(want.size), 32'(out_bus_size_code));
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_locked_access();
    test_unlock_select();
    test_enable_write();
    test_bus_requests();
    test_low_registers();
    test_output_backpressure();
    test_random_traffic();
    wait_replies_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
